@@ design/flsu_pkg.sv @@
// shared types, constants and width helpers for the flock steering unit
package flsu_pkg;

  // default flock capacity
  localparam int unsigned MaxMembersDef = 1024;

  // fixed field widths
  localparam int unsigned PosW   = 32;
  localparam int unsigned DirW   = 16;
  localparam int unsigned SpdW   = 31;
  localparam int unsigned GainW  = 24;
  localparam int unsigned OutW   = 32;
  localparam int unsigned VelW   = 48;
  localparam int unsigned CfgIdxW = 3;

  // fixed-point alignment shifts
  localparam int unsigned SepShift = 16;
  localparam int unsigned CohShift = 16;
  localparam int unsigned AliShift = 30;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_COH_GAIN = 3'd0,
    REG_SEP_GAIN = 3'd1,
    REG_ALI_GAIN = 3'd2,
    REG_COH_EXCL = 3'd3,
    REG_ALI_EXCL = 3'd4
  } cfg_reg_e;

  // shared unit operation
  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_ctl_t;

  typedef struct packed {
    logic [GainW-1:0] coh_gain;
    logic [GainW-1:0] sep_gain;
    logic [GainW-1:0] ali_gain;
    logic             coh_excl;
    logic             ali_excl;
  } cfg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL,
    ST_ACC,
    ST_NP,
    ST_SQ,
    ST_SEPM,
    ST_SEPD,
    ST_COHP,
    ST_COHM,
    ST_COHD,
    ST_ALIM,
    ST_ALID,
    ST_OUT
  } state_e;

  // member count width for a given capacity
  function automatic int unsigned cnt_width(input int unsigned max_members);
    return $clog2(max_members + 1);
  endfunction

  // shared unit operand width
  function automatic int unsigned unit_width(input int unsigned cw);
    return 2 * cw + 72;
  endfunction

  // quotient bits produced by one division
  function automatic int unsigned quo_width(input int unsigned cw);
    return cw + 42;
  endfunction

endpackage

@@ design/flsu_mdu.sv @@
// shared shift-add multiplier and restoring divider, one bit per cycle
module flsu_mdu import flsu_pkg::*; #(
  parameter int unsigned W  = 94,
  parameter int unsigned QW = 53
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mdu_ctl_t     ctl_i,
  input  logic [W-1:0] opa_i,
  input  logic [W-1:0] opb_i,
  output logic         done_o,
  output logic [W-1:0] res_o
);

  localparam int unsigned CntW = $clog2(QW + 1);

  logic            busy_q;
  logic            done_q;
  mdu_op_e         op_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    acc_q;
  logic [W-1:0]    a_q;
  logic [W-1:0]    b_q;

  logic [W:0]      trial;
  logic [W:0]      tdiff;
  logic            qbit;
  logic [W-1:0]    rem_nx;

  // one restoring division step: remainder in acc, quotient shifts through b
  always_comb begin
    trial  = {acc_q, b_q[QW-1]};
    tdiff  = trial - {1'b0, a_q};
    qbit   = (trial >= {1'b0, a_q});
    rem_nx = qbit ? tdiff[W-1:0] : trial[W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MDU_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctl_i.op;
        cnt_q  <= CntW'(QW);
      end else if (busy_q) begin
        if (op_q == MDU_MUL) begin
          if (b_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end else begin
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      if (ctl_i.op == MDU_MUL) begin
        acc_q <= '0;
        a_q   <= opa_i;
        b_q   <= opb_i;
      end else begin
        acc_q <= opa_i >> QW;
        b_q   <= W'(opa_i[QW-1:0]);
        a_q   <= opb_i;
      end
    end else if (busy_q) begin
      if (op_q == MDU_MUL) begin
        if (b_q != '0) begin
          if (b_q[0]) begin
            acc_q <= acc_q + a_q;
          end
          a_q <= a_q << 1;
          b_q <= b_q >> 1;
        end
      end else begin
        acc_q <= rem_nx;
        b_q   <= {b_q[W-2:0], qbit};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == MDU_MUL) ? acc_q : W'(b_q[QW-1:0]);

endmodule

@@ design/flsu_seq.sv @@
// sequencer, flock totals and per-axis term registers
module flsu_seq import flsu_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = MaxMembersDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   req_type_i,
  input  logic                   first_member_i,
  input  logic signed [PosW-1:0] pos_i [3],
  input  logic signed [DirW-1:0] dir_i [3],
  input  logic [SpdW-1:0]        speed_i,
  input  cfg_t                   cfg_i,
  output logic                   busy_o,
  output logic                   valid_o,
  output logic signed [OutW-1:0] steer_o [3],
  output logic                   skipped_o,
  output logic                   saturated_o,
  output mdu_ctl_t               mdu_ctl_o,
  output logic [unit_width(cnt_width(MAX_MEMBERS))-1:0] mdu_opa_o,
  output logic [unit_width(cnt_width(MAX_MEMBERS))-1:0] mdu_opb_o,
  input  logic                   mdu_done_i,
  input  logic [unit_width(cnt_width(MAX_MEMBERS))-1:0] mdu_res_i
);

  localparam int unsigned CW  = cnt_width(MAX_MEMBERS);
  localparam int unsigned W   = unit_width(CW);
  localparam int unsigned QW  = quo_width(CW);
  localparam int unsigned TPW = PosW + CW;
  localparam int unsigned TVW = VelW + CW;
  localparam int unsigned DW  = PosW + CW + 1;
  localparam int unsigned XW  = PosW + CW + 2;
  localparam int unsigned AW  = TVW + 1;
  localparam int unsigned RW  = QW + 3;

  state_e state_q, state_d;
  logic   wait_q;
  logic [1:0] ax_q;
  logic [CW-1:0] cnt_q;
  logic signed [TPW-1:0] tp_q [3];
  logic signed [TVW-1:0] tv_q [3];

  // latched item
  logic                   type_q;
  logic                   first_q;
  logic signed [PosW-1:0] p_q [3];
  logic signed [DirW-1:0] dir_q [3];
  logic [SpdW-1:0]        spd_q;

  // working registers
  logic signed [VelW-1:0] v_q [3];
  logic signed [DW-1:0]   d_q [3];
  logic [W-1:0]           s_q;
  logic signed [XW-1:0]   x_q;
  logic signed [RW-1:0]   res_q [3];
  logic                   skip_q;

  // selected axis and derived values
  logic signed [PosW-1:0] p_s;
  logic signed [PosW:0]   p_ext;
  logic [PosW:0]          p_mag;
  logic signed [DirW:0]   dir_ext;
  logic [DirW:0]          dir_mag;
  logic signed [DW-1:0]   d_s;
  logic [DW-1:0]          d_mag;
  logic [XW-1:0]          x_mag;
  logic signed [AW-1:0]   a_s;
  logic [AW-1:0]          a_mag;
  logic signed [DW-1:0]   np_s;
  logic signed [XW-1:0]   mcp_s;
  logic signed [VelW-1:0] vm_s;
  logic signed [RW-1:0]   q_ext;
  logic signed [RW-1:0]   q_s;
  logic [W-1:0]           s_nx;
  logic [CW-1:0]          mc;
  logic [CW-1:0]          ma;
  logic                   n_gt1, mc_pos, ma_pos;
  logic                   op_state, issue, fin, last_ax, loop_end, div_neg;
  state_e                 after_sep, after_coh;
  logic [CW-1:0]          cnt_base;
  logic                   room;
  logic signed [TPW-1:0]  tp_acc [3];
  logic signed [TVW-1:0]  tv_acc [3];

  // per-axis operands and signs
  always_comb begin
    p_s     = p_q[ax_q];
    p_ext   = (PosW+1)'(p_s);
    p_mag   = p_ext[PosW] ? unsigned'(-p_ext) : unsigned'(p_ext);
    dir_ext = (DirW+1)'(dir_q[ax_q]);
    dir_mag = dir_ext[DirW] ? unsigned'(-dir_ext) : unsigned'(dir_ext);
    d_s     = d_q[ax_q];
    d_mag   = d_s[DW-1] ? unsigned'(-d_s) : unsigned'(d_s);
    x_mag   = x_q[XW-1] ? unsigned'(-x_q) : unsigned'(x_q);
    a_s     = AW'(tv_q[ax_q]) - (cfg_i.ali_excl ? AW'(v_q[ax_q]) : '0);
    a_mag   = a_s[AW-1] ? unsigned'(-a_s) : unsigned'(a_s);
  end

  // results coming back from the shared unit
  always_comb begin
    np_s  = signed'({1'b0, mdu_res_i[DW-2:0]});
    mcp_s = signed'({1'b0, mdu_res_i[XW-2:0]});
    vm_s  = signed'({1'b0, mdu_res_i[VelW-2:0]});
    q_ext = signed'({3'b000, mdu_res_i[QW-1:0]});
    s_nx  = ((ax_q == 2'd0) ? '0 : s_q) + mdu_res_i;
    case (state_q)
      ST_SEPD: div_neg = d_s[DW-1];
      ST_COHD: div_neg = x_q[XW-1];
      default: div_neg = a_s[AW-1];
    endcase
    q_s = div_neg ? -q_ext : q_ext;
  end

  // flock size conditions
  always_comb begin
    mc     = cnt_q - CW'(cfg_i.coh_excl);
    ma     = cnt_q - CW'(cfg_i.ali_excl);
    n_gt1  = cnt_q > CW'(1);
    mc_pos = cnt_q > CW'(cfg_i.coh_excl);
    ma_pos = cnt_q > CW'(cfg_i.ali_excl);
    after_coh = ma_pos ? ST_ALIM : ST_OUT;
    after_sep = mc_pos ? ST_COHP : after_coh;
  end

  // add item: optional clear, then add unless the flock is full
  always_comb begin
    cnt_base = first_q ? '0 : cnt_q;
    room     = cnt_base < CW'(MAX_MEMBERS);
    for (int k = 0; k < 3; k++) begin
      tp_acc[k] = (first_q ? '0 : tp_q[k]) + (room ? TPW'(p_q[k]) : '0);
      tv_acc[k] = (first_q ? '0 : tv_q[k]) + (room ? TVW'(v_q[k]) : '0);
    end
  end

  // handshake with the shared unit
  always_comb begin
    op_state = (state_q != ST_IDLE) && (state_q != ST_ACC) && (state_q != ST_OUT);
    issue    = op_state && !wait_q;
    fin      = wait_q && mdu_done_i;
    last_ax  = (ax_q == 2'd2);
    loop_end = (state_q == ST_VEL) || (state_q == ST_NP) || (state_q == ST_SQ) ||
               (state_q == ST_SEPD) || (state_q == ST_COHD) || (state_q == ST_ALID);
  end

  // next state and shared unit operands
  always_comb begin
    state_d       = state_q;
    mdu_ctl_o.start = issue;
    mdu_ctl_o.op  = MDU_MUL;
    mdu_opa_o     = '0;
    mdu_opb_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_VEL;
      end
      ST_VEL: begin
        mdu_opa_o = W'(spd_q);
        mdu_opb_o = W'(dir_mag);
        if (fin && last_ax) state_d = type_q ? ST_NP : ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_IDLE;
      end
      ST_NP: begin
        mdu_opa_o = W'(p_mag);
        mdu_opb_o = W'(cnt_q);
        if (fin && last_ax) state_d = n_gt1 ? ST_SQ : after_sep;
      end
      ST_SQ: begin
        mdu_opa_o = W'(d_mag);
        mdu_opb_o = W'(d_mag);
        if (fin && last_ax) state_d = (s_nx == '0) ? after_sep : ST_SEPM;
      end
      ST_SEPM: begin
        mdu_opa_o = W'(d_mag);
        mdu_opb_o = W'(cfg_i.sep_gain);
        if (fin) state_d = ST_SEPD;
      end
      ST_SEPD: begin
        mdu_ctl_o.op = MDU_DIV;
        mdu_opa_o    = mdu_res_i << SepShift;
        mdu_opb_o    = s_q;
        if (fin) state_d = last_ax ? after_sep : ST_SEPM;
      end
      ST_COHP: begin
        mdu_opa_o = W'(p_mag);
        mdu_opb_o = W'(mc);
        if (fin) state_d = ST_COHM;
      end
      ST_COHM: begin
        mdu_opa_o = W'(x_mag);
        mdu_opb_o = W'(cfg_i.coh_gain);
        if (fin) state_d = ST_COHD;
      end
      ST_COHD: begin
        mdu_ctl_o.op = MDU_DIV;
        mdu_opa_o    = mdu_res_i >> CohShift;
        mdu_opb_o    = W'(mc);
        if (fin) state_d = last_ax ? after_coh : ST_COHP;
      end
      ST_ALIM: begin
        mdu_opa_o = W'(a_mag);
        mdu_opb_o = W'(cfg_i.ali_gain);
        if (fin) state_d = ST_ALID;
      end
      ST_ALID: begin
        mdu_ctl_o.op = MDU_DIV;
        mdu_opa_o    = mdu_res_i >> AliShift;
        mdu_opb_o    = W'(ma);
        if (fin) state_d = last_ax ? ST_OUT : ST_ALIM;
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state, axis counter and flock totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
      ax_q    <= '0;
      cnt_q   <= '0;
      for (int k = 0; k < 3; k++) begin
        tp_q[k] <= '0;
        tv_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (issue) begin
        wait_q <= 1'b1;
      end else if (fin) begin
        wait_q <= 1'b0;
      end
      if (state_q == ST_IDLE) begin
        ax_q <= '0;
      end else if (fin && loop_end) begin
        ax_q <= last_ax ? 2'd0 : ax_q + 2'd1;
      end
      if (state_q == ST_ACC) begin
        cnt_q <= room ? cnt_base + CW'(1) : cnt_base;
        for (int k = 0; k < 3; k++) begin
          tp_q[k] <= tp_acc[k];
          tv_q[k] <= tv_acc[k];
        end
      end
    end
  end

  // item latch and term registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      type_q  <= req_type_i;
      first_q <= first_member_i;
      spd_q   <= speed_i;
      skip_q  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        p_q[k]   <= pos_i[k];
        dir_q[k] <= dir_i[k];
        res_q[k] <= '0;
      end
    end
    if (fin) begin
      case (state_q)
        ST_VEL:  v_q[ax_q] <= dir_ext[DirW] ? -vm_s : vm_s;
        ST_NP:   d_q[ax_q] <= (p_ext[PosW] ? -np_s : np_s) - DW'(tp_q[ax_q]);
        ST_SQ: begin
          s_q <= s_nx;
          if (last_ax && s_nx == '0) skip_q <= 1'b1;
        end
        ST_COHP: x_q <= XW'(tp_q[ax_q]) - (cfg_i.coh_excl ? XW'(p_s) : '0)
                        - (p_ext[PosW] ? -mcp_s : mcp_s);
        ST_SEPD, ST_COHD, ST_ALID: res_q[ax_q] <= res_q[ax_q] + q_s;
        default: ;
      endcase
    end
  end

  // clamp to the output range
  localparam logic signed [RW-1:0] SatHi = RW'({1'b0, {(OutW-1){1'b1}}});
  localparam logic signed [RW-1:0] SatLo = -SatHi - RW'(1);

  always_comb begin
    saturated_o = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (res_q[k] > SatHi) begin
        steer_o[k]  = SatHi[OutW-1:0];
        saturated_o = 1'b1;
      end else if (res_q[k] < SatLo) begin
        steer_o[k]  = SatLo[OutW-1:0];
        saturated_o = 1'b1;
      end else begin
        steer_o[k]  = res_q[k][OutW-1:0];
      end
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign valid_o   = (state_q == ST_OUT);
  assign skipped_o = skip_q;

endmodule

@@ design/flock_steering_unit_core.sv @@
// flock steering unit top level: configuration registers, sequencer and shared unit
//
// Add items fold one member into the flock totals unless the flock is full;
// steer items return one result with cohesion, alignment and separation
// summed per axis in signed Q16.16. An item is taken when start is high and
// busy is low; busy then stays high until the item is done. All multiplies
// and divides run on one shared shift-add multiplier / restoring divider: a
// multiply steps through its multiplier bit positions up to the top set bit
// (heading 16, count, gain 24, distance up to clog2(MAX_MEMBERS+1)+32 bits)
// and a divide yields clog2(MAX_MEMBERS+1)+42 quotient bits, each operation
// issued and handed back over a start/done handshake. A steer item finishes
// sooner when terms drop out. The result shows on the outputs for exactly
// one cycle with result_valid_o high and cannot be held off by the receiver.
// Configuration writes take effect at once and must only be made while busy
// is low.
module flock_steering_unit_core import flsu_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = MaxMembersDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [GainW-1:0]       cfg_wdata_i,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type_i,
  input  logic                   first_member_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  input  logic signed [DirW-1:0] dir_x_i,
  input  logic signed [DirW-1:0] dir_y_i,
  input  logic signed [DirW-1:0] dir_z_i,
  input  logic [SpdW-1:0]        speed_i,
  output logic                   result_valid_o,
  output logic signed [OutW-1:0] steer_x_o,
  output logic signed [OutW-1:0] steer_y_o,
  output logic signed [OutW-1:0] steer_z_o,
  output logic                   separation_skipped_o,
  output logic                   saturated_o
);

  localparam int unsigned CW = cnt_width(MAX_MEMBERS);
  localparam int unsigned W  = unit_width(CW);
  localparam int unsigned QW = quo_width(CW);

  cfg_t cfg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COH_GAIN: cfg_q.coh_gain <= cfg_wdata_i;
        REG_SEP_GAIN: cfg_q.sep_gain <= cfg_wdata_i;
        REG_ALI_GAIN: cfg_q.ali_gain <= cfg_wdata_i;
        REG_COH_EXCL: cfg_q.coh_excl <= cfg_wdata_i[0];
        REG_ALI_EXCL: cfg_q.ali_excl <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // per-axis item fields
  logic signed [PosW-1:0] pos [3];
  logic signed [DirW-1:0] dir [3];
  logic signed [OutW-1:0] steer [3];

  assign pos = '{pos_x_i, pos_y_i, pos_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};

  mdu_ctl_t     mdu_ctl;
  logic [W-1:0] mdu_opa, mdu_opb, mdu_res;
  logic         mdu_done;

  flsu_seq #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .req_type_i     (req_type_i),
    .first_member_i (first_member_i),
    .pos_i          (pos),
    .dir_i          (dir),
    .speed_i        (speed_i),
    .cfg_i          (cfg_q),
    .busy_o         (busy),
    .valid_o        (result_valid_o),
    .steer_o        (steer),
    .skipped_o      (separation_skipped_o),
    .saturated_o    (saturated_o),
    .mdu_ctl_o      (mdu_ctl),
    .mdu_opa_o      (mdu_opa),
    .mdu_opb_o      (mdu_opb),
    .mdu_done_i     (mdu_done),
    .mdu_res_i      (mdu_res)
  );

  flsu_mdu #(
    .W  (W),
    .QW (QW)
  ) u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mdu_ctl),
    .opa_i  (mdu_opa),
    .opb_i  (mdu_opb),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  assign steer_x_o = steer[0];
  assign steer_y_o = steer[1];
  assign steer_z_o = steer[2];

endmodule

@@ design/flsu_chk.sv @@
// port-level checks for the flock steering unit, bound to the top level
module flsu_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  // an accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only appears while an item is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  // a result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // the block is free right after delivering a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy)
    else $error("busy after result delivered");

endmodule

bind flock_steering_unit_core flsu_chk u_flsu_chk (.*);

@@ verif/flock_steering_unit_core_tb.sv @@
// self-checking testbench for the flock steering unit core
module flock_steering_unit_core_tb;
  import flsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FlockCap   = MaxMembersDef;
  localparam longint      CycleLimit = 40_000_000;

  // one input item
  typedef struct packed {
    logic                   steer;
    logic                   first;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [PosW-1:0] pz;
    logic signed [DirW-1:0] dx;
    logic signed [DirW-1:0] dy;
    logic signed [DirW-1:0] dz;
    logic [SpdW-1:0]        spd;
  } flock_item_t;

  // one steering result
  typedef struct packed {
    logic signed [OutW-1:0] sx;
    logic signed [OutW-1:0] sy;
    logic signed [OutW-1:0] sz;
    logic                   skipped;
    logic                   sat;
  } steer_res_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [GainW-1:0]       cfg_wdata_i;
  logic                   start;
  logic                   busy;
  logic                   req_type_i;
  logic                   first_member_i;
  logic signed [PosW-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [DirW-1:0] dir_x_i, dir_y_i, dir_z_i;
  logic [SpdW-1:0]        speed_i;
  logic                   result_valid_o;
  logic signed [OutW-1:0] steer_x_o, steer_y_o, steer_z_o;
  logic                   separation_skipped_o;
  logic                   saturated_o;

  flock_steering_unit_core u_top (.*);

  // flock totals and register copy kept by the predictor
  longint      flock_pos_sum[3];
  longint      flock_vel_sum[3];
  longint      flock_size;
  longint      gain_coh, gain_sep, gain_ali;
  longint      excl_coh, excl_ali;

  steer_res_t  pending_steer[$];
  int unsigned mismatch_cnt;
  longint      cycle_cnt;
  bit          idle_en;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] abs64(input longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // trunc(|x| * g / den) with the sign of x
  function automatic longint div_signed(input longint x, input logic [127:0] num,
                                        input logic [127:0] den);
    logic [127:0] q;
    q = num / den;
    return x < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // predicted steering for one body against the current flock totals
  function automatic steer_res_t steer_predict(input flock_item_t it);
    longint       p[3], v[3], d[3], acc[3];
    longint       mc, ma, c;
    logic [127:0] dist2, den;
    steer_res_t   r;
    p = '{longint'(it.px), longint'(it.py), longint'(it.pz)};
    v = '{longint'(it.dx) * longint'(it.spd), longint'(it.dy) * longint'(it.spd),
          longint'(it.dz) * longint'(it.spd)};
    mc = flock_size - excl_coh;
    ma = flock_size - excl_ali;
    r.skipped = 1'b0;
    r.sat = 1'b0;
    dist2 = '0;
    for (int k = 0; k < 3; k++) begin
      d[k] = flock_size * p[k] - flock_pos_sum[k];
      acc[k] = 0;
      dist2 += 128'(abs64(d[k])) * 128'(abs64(d[k]));
    end
    // separation away from the flock
    if (flock_size > 1) begin
      if (dist2 == 0) begin
        r.skipped = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++)
          acc[k] += div_signed(d[k], (128'(abs64(d[k])) * 128'(gain_sep)) << SepShift,
                               dist2);
      end
    end
    // cohesion toward the centroid
    if (mc > 0) begin
      den = 128'(mc) << CohShift;
      for (int k = 0; k < 3; k++) begin
        c = flock_pos_sum[k] - (excl_coh != 0 ? p[k] : 0) - mc * p[k];
        acc[k] += div_signed(c, 128'(abs64(c)) * 128'(gain_coh), den);
      end
    end
    // alignment toward the mean velocity
    if (ma > 0) begin
      den = 128'(ma) << AliShift;
      for (int k = 0; k < 3; k++) begin
        c = flock_vel_sum[k] - (excl_ali != 0 ? v[k] : 0);
        acc[k] += div_signed(c, 128'(abs64(c)) * 128'(gain_ali), den);
      end
    end
    // clamp to the output range
    for (int k = 0; k < 3; k++) begin
      if (acc[k] > 64'sd2147483647) begin
        acc[k] = 64'sd2147483647;
        r.sat = 1'b1;
      end
      if (acc[k] < -64'sd2147483648) begin
        acc[k] = -64'sd2147483648;
        r.sat = 1'b1;
      end
    end
    r.sx = acc[0][31:0];
    r.sy = acc[1][31:0];
    r.sz = acc[2][31:0];
    return r;
  endfunction

  // fold an accepted item into the predictor
  function automatic void flock_update(input flock_item_t it);
    if (it.steer) begin
      pending_steer.push_back(steer_predict(it));
    end else begin
      if (it.first) begin
        flock_pos_sum = '{0, 0, 0};
        flock_vel_sum = '{0, 0, 0};
        flock_size = 0;
      end
      if (flock_size < FlockCap) begin
        flock_pos_sum[0] += longint'(it.px);
        flock_pos_sum[1] += longint'(it.py);
        flock_pos_sum[2] += longint'(it.pz);
        flock_vel_sum[0] += longint'(it.dx) * longint'(it.spd);
        flock_vel_sum[1] += longint'(it.dy) * longint'(it.spd);
        flock_vel_sum[2] += longint'(it.dz) * longint'(it.spd);
        flock_size++;
      end
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    steer_res_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_steer.size() == 0) begin
        $error("unexpected result");
        mismatch_cnt++;
      end else begin
        want = pending_steer.pop_front();
        if (steer_x_o !== want.sx) begin
          $error("steer_x expected %0d got %0d", want.sx, steer_x_o);
          mismatch_cnt++;
        end
        if (steer_y_o !== want.sy) begin
          $error("steer_y expected %0d got %0d", want.sy, steer_y_o);
          mismatch_cnt++;
        end
        if (steer_z_o !== want.sz) begin
          $error("steer_z expected %0d got %0d", want.sz, steer_z_o);
          mismatch_cnt++;
        end
        if (separation_skipped_o !== want.skipped) begin
          $error("separation_skipped expected %0b got %0b", want.skipped,
                 separation_skipped_o);
          mismatch_cnt++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated expected %0b got %0b", want.sat, saturated_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // send one item, waiting for the block to take it
  task automatic send_item(input flock_item_t it);
    if (idle_en && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start          <= 1'b1;
    req_type_i     <= it.steer;
    first_member_i <= it.first;
    pos_x_i        <= it.px;
    pos_y_i        <= it.py;
    pos_z_i        <= it.pz;
    dir_x_i        <= it.dx;
    dir_y_i        <= it.dy;
    dir_z_i        <= it.dz;
    speed_i        <= it.spd;
    do @(posedge clk_i); while (busy !== 1'b0);
    flock_update(it);
  endtask

  // stop sending and let the block finish all work
  task automatic drain_flock;
    start <= 1'b0;
    do @(posedge clk_i); while (pending_steer.size() != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk_i);
  endtask

  // one register write, then the write enable is dropped
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_COH_GAIN: gain_coh = longint'(val);
      REG_SEP_GAIN: gain_sep = longint'(val);
      REG_ALI_GAIN: gain_ali = longint'(val);
      REG_COH_EXCL: excl_coh = longint'(val[0]);
      REG_ALI_EXCL: excl_ali = longint'(val[0]);
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [GainW-1:0] gc, input logic [GainW-1:0] gs,
                           input logic [GainW-1:0] ga, input logic ec, input logic ea);
    write_reg(REG_COH_GAIN, gc);
    write_reg(REG_SEP_GAIN, gs);
    write_reg(REG_ALI_GAIN, ga);
    write_reg(REG_COH_EXCL, {23'h0, ec});
    write_reg(REG_ALI_EXCL, {23'h0, ea});
  endtask

  // random position: mostly a small cluster, sometimes anywhere
  function automatic logic [PosW-1:0] rand_pos(input bit wide);
    if (wide) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
  endfunction

  function automatic flock_item_t rand_item(input bit steer, input bit first,
                                            input bit wide);
    flock_item_t it;
    it.steer = steer;
    it.first = first;
    it.px = rand_pos(wide);
    it.py = rand_pos(wide);
    it.pz = rand_pos(wide);
    it.dx = 16'($urandom);
    it.dy = 16'($urandom);
    it.dz = 16'($urandom);
    it.spd = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0010_0000));
    return it;
  endfunction

  function automatic flock_item_t fixed_item(input bit steer, input bit first,
                                             input logic [PosW-1:0] pos,
                                             input logic [DirW-1:0] dir,
                                             input logic [SpdW-1:0] spd);
    flock_item_t it;
    it = '{steer, first, pos, pos, pos, dir, dir, dir, spd};
    return it;
  endfunction

  // steering against an empty flock, with and without self exclusion
  task automatic test_empty_flock;
    write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1);
    send_item(rand_item(1'b1, 1'b0, 1'b1));
    drain_flock();
    write_all(24'h01_0000, 24'h01_0000, 24'h01_0000, 1'b0, 1'b0);
    send_item(rand_item(1'b1, 1'b1, 1'b1));
    drain_flock();
  endtask

  // field extremes, single member, coincident bodies and saturation
  task automatic test_directed;
    // single member flock, both exclusion settings
    send_item(fixed_item(1'b0, 1'b1, 32'h7FFF_FFFF, 16'h7FFF, 31'h7FFF_FFFF));
    send_item(fixed_item(1'b1, 1'b0, 32'h8000_0000, 16'h8000, 31'h7FFF_FFFF));
    drain_flock();
    write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1);
    send_item(fixed_item(1'b1, 1'b1, 32'h0000_0000, 16'h0000, 31'h0));
    // two members at opposite extremes
    send_item(fixed_item(1'b0, 1'b0, 32'h8000_0000, 16'h8000, 31'h7FFF_FFFF));
    send_item(fixed_item(1'b1, 1'b0, 32'h7FFF_FFFF, 16'h7FFF, 31'h7FFF_FFFF));
    send_item(fixed_item(1'b1, 1'b0, 32'h8000_0000, 16'hFFFF, 31'h1));
    send_item(fixed_item(1'b1, 1'b0, 32'hFFFF_FFFF, 16'h4000, 31'h0001_0000));
    drain_flock();
    // coincident bodies: separation skipped
    write_all(24'h00_8000, 24'hFF_FFFF, 24'h00_0001, 1'b0, 1'b1);
    send_item(fixed_item(1'b0, 1'b1, 32'h0001_0000, 16'h4000, 31'h0002_0000));
    send_item(fixed_item(1'b0, 1'b0, 32'h0001_0000, 16'hC000, 31'h0002_0000));
    send_item(fixed_item(1'b0, 1'b0, 32'h0001_0000, 16'h0000, 31'h0));
    send_item(fixed_item(1'b1, 1'b0, 32'h0001_0000, 16'h4000, 31'h0001_0000));
    // tiny offset: huge separation, saturates
    send_item(fixed_item(1'b1, 1'b1, 32'h0001_0001, 16'h4000, 31'h0001_0000));
    drain_flock();
    write_all(24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
    send_item(rand_item(1'b1, 1'b0, 1'b1));
    drain_flock();
    // out of range register index is ignored
    write_reg(3'd7, 24'hFF_FFFF);
    write_reg(3'd5, 24'hFF_FFFF);
    send_item(rand_item(1'b1, 1'b0, 1'b1));
    drain_flock();
  endtask

  // fill the flock past capacity
  task automatic test_full_flock;
    write_all(24'h00_4000, 24'h01_0000, 24'h00_4000, 1'b1, 1'b0);
    for (int i = 0; i < FlockCap + 6; i++)
      send_item(rand_item(1'b0, i == 0, 1'b0));
    send_item(rand_item(1'b1, 1'b0, 1'b0));
    send_item(rand_item(1'b1, 1'b0, 1'b1));
    // clearing a full flock still adds the member
    send_item(rand_item(1'b0, 1'b1, 1'b0));
    send_item(rand_item(1'b1, 1'b0, 1'b0));
    drain_flock();
  endtask

  // random flocks under a series of register settings
  task automatic test_random;
    int unsigned sent;
    int unsigned members;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1);
        1: write_all(24'h00_0001, 24'h00_0001, 24'h00_0001, 1'b0, 1'b0);
        default: write_all(24'($urandom), 24'($urandom), 24'($urandom),
                           1'($urandom), 1'($urandom));
      endcase
      idle_en = (ph != 3);
      sent = 0;
      while (sent < 30) begin
        if ($urandom_range(9) == 0) begin
          // stray items
          send_item(rand_item(1'($urandom), 1'($urandom), 1'($urandom)));
          sent++;
        end else begin
          members = $urandom_range(7) == 0 ? $urandom_range(9, 30) : $urandom_range(1, 6);
          for (int i = 0; i < members; i++)
            send_item(rand_item(1'b0, i == 0, $urandom_range(4) == 0));
          repeat ($urandom_range(1, 3))
            send_item(rand_item(1'b1, 1'($urandom), $urandom_range(4) == 0));
          sent += members + 2;
        end
        // sender holds off until everything is back
        if (ph == 5 && sent >= 10 && sent < 45) drain_flock();
      end
      drain_flock();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    start          = 1'b0;
    req_type_i     = 1'b0;
    first_member_i = 1'b0;
    pos_x_i        = '0;
    pos_y_i        = '0;
    pos_z_i        = '0;
    dir_x_i        = '0;
    dir_y_i        = '0;
    dir_z_i        = '0;
    speed_i        = '0;
    flock_pos_sum  = '{0, 0, 0};
    flock_vel_sum  = '{0, 0, 0};
    flock_size     = 0;
    gain_coh       = 0;
    gain_sep       = 0;
    gain_ali       = 0;
    excl_coh       = 0;
    excl_ali       = 0;
    mismatch_cnt   = 0;
    idle_en        = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_flock();
    test_directed();
    test_full_flock();
    test_random();

    drain_flock();
    repeat (1000) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_steer.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
